@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker modules.
// Each expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ hdl/tcof_pkg.sv @@
package tcof_pkg;

   // Default sizes
   localparam int DEPTH_DEFAULT    = 16;
   localparam int ID_WIDTH_DEFAULT = 16;

   // Field widths on the ports
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int PORT_ID_W = 16;
   localparam int WIDE_ID_W = 32;

   // Request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQ      = 2'd0,
      ACT_DEQ_ANY  = 2'd1,
      ACT_DEQ_K0   = 2'd2,
      ACT_DEQ_K1   = 2'd3
   } action_type;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Command broadcast to every cell in the chain
   typedef struct packed {
      logic enq;    // append at the young end
      logic deq;    // remove oldest match
      logic any;    // dequeue ignores kind
      logic kind;   // kind to store, or kind to match
   } cmd_type;

endpackage

@@ hdl/tcof_cell.sv @@
module tcof_cell
   import tcof_pkg::*;
#(
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [ID_WIDTH-1:0] enq_handle,
   // older neighbor
   input  logic                prev_valid,
   input  logic                found_in,
   input  logic [ID_WIDTH-1:0] pick_handle_in,
   input  logic                pick_kind_in,
   // younger neighbor
   input  logic                next_valid,
   input  logic [ID_WIDTH-1:0] next_handle,
   input  logic                next_kind,
   // own state, seen by neighbors
   output logic                valid,
   output logic [ID_WIDTH-1:0] handle,
   output logic                kind,
   output logic                found_out,
   output logic [ID_WIDTH-1:0] pick_handle_out,
   output logic                pick_kind_out
);

   logic                valid_ff, valid_in;
   logic [ID_WIDTH-1:0] handle_ff, handle_in;
   logic                kind_ff, kind_in;
   logic                match, hit, shift, load;

   // Oldest-match search: first matching cell not preceded by a match
   assign match     = valid_ff && (cmd.any || (kind_ff == cmd.kind));
   assign hit       = match && !found_in;
   assign found_out = found_in || hit;
   assign shift     = cmd.deq && found_out;
   assign load      = cmd.enq && !valid_ff && prev_valid;

   // Hit cell drives the picked entry down the chain
   assign pick_handle_out = hit ? handle_ff : pick_handle_in;
   assign pick_kind_out   = hit ? kind_ff : pick_kind_in;

   // Next state: shift from younger neighbor, or take the new entry
   always_comb begin
      valid_in  = valid_ff;
      handle_in = handle_ff;
      kind_in   = kind_ff;
      if (shift) begin
         valid_in  = next_valid;
         handle_in = next_handle;
         kind_in   = next_kind;
      end else if (load) begin
         valid_in  = 1'b1;
         handle_in = enq_handle;
         kind_in   = cmd.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      kind_ff   <= kind_in;
   end

   assign valid  = valid_ff;
   assign handle = handle_ff;
   assign kind   = kind_ff;

endmodule

@@ hdl/two_class_ordered_fifo.sv @@
// Channel | Dir | tdata                | tuser
// req_    | in  | [15:0] item_id       | [1:0] action, [2] item_kind
// rsp_    | out | [15:0] out_id        | [1:0] status, [2] out_kind
//
// One request per cycle unless a stalled response holds it off; each request
// gives its response on the next cycle. The ripple oldest-match search through
// the DEPTH-cell chain is combinational; it resolves and shifts the store in the same cycle.
// Reset empties the queue at once; no clearing pass is needed.
// A stalled response holds the next request off only while it waits.
module two_class_ordered_fifo
   import tcof_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] item_id
   input  logic [2:0]  req_tuser,   // [1:0] action, [2] item_kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_id
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] out_kind
);

   logic                fire;
   action_type          action;
   cmd_type             cmd;
   logic [WIDE_ID_W-1:0] id_wide, pick_wide;
   logic [ID_WIDTH-1:0] enq_handle;

   logic                valid_v [DEPTH+1];
   logic [ID_WIDTH-1:0] handle_v [DEPTH+1];
   logic                kind_v [DEPTH+1];
   logic                prev_v [DEPTH];
   logic                found_v [DEPTH+1];
   logic [ID_WIDTH-1:0] pick_h_v [DEPTH+1];
   logic                pick_k_v [DEPTH+1];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PORT_ID_W-1:0] id_ff, id_in;
   logic                kind_ff, kind_in;

   // Handshake: take a request whenever the response slot frees up
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   // Decode the request into the chain command
   assign action     = action_type'(req_tuser[1:0]);
   assign id_wide    = WIDE_ID_W'(req_tdata);
   assign enq_handle = id_wide[ID_WIDTH-1:0];

   always_comb begin
      cmd = '0;
      case (action)
         ACT_ENQ: begin
            cmd.enq  = fire;
            cmd.kind = req_tuser[2];
         end
         ACT_DEQ_ANY: begin
            cmd.deq = fire;
            cmd.any = 1'b1;
         end
         ACT_DEQ_K0: begin
            cmd.deq  = fire;
            cmd.kind = 1'b0;
         end
         ACT_DEQ_K1: begin
            cmd.deq  = fire;
            cmd.kind = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Chain ends
   assign valid_v[DEPTH]  = 1'b0;
   assign handle_v[DEPTH] = '0;
   assign kind_v[DEPTH]   = 1'b0;
   assign found_v[0]      = 1'b0;
   assign pick_h_v[0]     = '0;
   assign pick_k_v[0]     = 1'b0;

   // Cell chain, cell 0 holds the oldest entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_v[i] = 1'b1;
      end else begin : g_body
         assign prev_v[i] = valid_v[i-1];
      end

      tcof_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .enq_handle      (enq_handle),
         .prev_valid      (prev_v[i]),
         .found_in        (found_v[i]),
         .pick_handle_in  (pick_h_v[i]),
         .pick_kind_in    (pick_k_v[i]),
         .next_valid      (valid_v[i+1]),
         .next_handle     (handle_v[i+1]),
         .next_kind       (kind_v[i+1]),
         .valid           (valid_v[i]),
         .handle          (handle_v[i]),
         .kind            (kind_v[i]),
         .found_out       (found_v[i+1]),
         .pick_handle_out (pick_h_v[i+1]),
         .pick_kind_out   (pick_k_v[i+1])
      );
   end

   // Response contents; the picked entry is zero when nothing matched
   assign pick_wide = WIDE_ID_W'(pick_h_v[DEPTH]);

   always_comb begin
      status_in = ST_OK;
      id_in     = '0;
      kind_in   = 1'b0;
      if (action == ACT_ENQ) begin
         if (valid_v[DEPTH-1]) begin
            status_in = ST_FULL;
         end
      end else if (found_v[DEPTH]) begin
         id_in   = pick_wide[PORT_ID_W-1:0];
         kind_in = pick_k_v[DEPTH];
      end else begin
         status_in = ST_EMPTY;
      end
   end

   // Response register
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         kind_ff   <= kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = id_ff;
   assign rsp_tuser  = {kind_ff, status_ff};

endmodule

@@ hdl/tcof_checker.sv @@
`include "assert_macros.svh"

module tcof_checker
   import tcof_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // No response comes out of reset
   `ASSERT_CLK_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "response valid after reset")

   // Every accepted request has its response on the next cycle
   `ASSERT_CLK(a_req_to_rsp, (req_tvalid && req_tready) |=> rsp_tvalid, "response missing")

   // Status is one of the three defined codes
   `ASSERT_CLK(a_status_code, rsp_tvalid |-> (rsp_tuser[1:0] == ST_OK || rsp_tuser[1:0] == ST_EMPTY || rsp_tuser[1:0] == ST_FULL), "bad status")

   // Failed requests carry no item
   `ASSERT_CLK(a_fail_zero, (rsp_tvalid && rsp_tuser[1:0] != ST_OK) |-> (rsp_tdata == '0 && !rsp_tuser[2]), "item on failed request")

   // A stalled response holds
   `ASSERT_CLK(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled response changed")

endmodule

bind two_class_ordered_fifo tcof_checker u_tcof_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tcof_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_PCT     = 35;
   localparam int QUIET_FIRST  = 400;   // random items in [QUIET_FIRST, QUIET_LAST) never idle
   localparam int QUIET_LAST   = 750;
   localparam int DRAIN_AT     = 1100;  // sender holds off here until all responses are back
   localparam int SLOTS        = DEPTH_DEFAULT;

   // One response as the queue reports it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [15:0]         out_id;
      logic                out_kind;
   } fifo_rsp_t;

   // One stored entry of the mirror queue
   typedef struct packed {
      logic [15:0] handle;
      logic        kind;
   } slot_t;

   // One row of the directed table; typed rows carry their response
   typedef struct {
      action_type  act;
      logic [15:0] id;
      logic        kind;
      bit          typed;
      fifo_rsp_t   rsp;
   } dir_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] item_id
   logic [2:0]  req_tuser;   // [1:0] action, [2] item_kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] out_id
   logic [2:0]  rsp_tuser;   // [1:0] status, [2] out_kind

   slot_t     mirror_slots[$];
   fifo_rsp_t awaited_rsp[$];
   dir_row_t  dir_rows[$];
   int        mismatch_count = 0;
   bit        quiet = 0;

   two_class_ordered_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one request to the mirror queue and returns the response it gives
   function automatic fifo_rsp_t mirror_apply(input action_type act, input logic [15:0] id,
                                              input logic kind);
      fifo_rsp_t r;
      int        pos;
      r   = '{status: ST_OK, out_id: '0, out_kind: 1'b0};
      pos = -1;
      if (act == ACT_ENQ) begin
         if (mirror_slots.size() >= SLOTS) begin
            r.status = ST_FULL;
         end else begin
            mirror_slots.push_back('{handle: id, kind: kind});
         end
      end else begin
         // oldest entry that matches the selector
         for (int i = 0; i < mirror_slots.size(); i++) begin
            if (pos < 0 && (act == ACT_DEQ_ANY ||
                            mirror_slots[i].kind == (act == ACT_DEQ_K1))) begin
               pos = i;
            end
         end
         if (pos < 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.out_id   = mirror_slots[pos].handle;
            r.out_kind = mirror_slots[pos].kind;
            mirror_slots.delete(pos);
         end
      end
      return r;
   endfunction

   function automatic void add_row(input action_type act, input logic [15:0] id,
                                   input logic kind, input bit typed,
                                   input logic [STATUS_W-1:0] status);
      dir_row_t row;
      row.act   = act;
      row.id    = id;
      row.kind  = kind;
      row.typed = typed;
      row.rsp   = '{status: status, out_id: '0, out_kind: 1'b0};
      dir_rows.push_back(row);
   endfunction

   // Drives one request from a falling edge, waits for it to be taken, returns at a falling edge
   task automatic send_request(input action_type act, input logic [15:0] id, input logic kind,
                               input bit typed, input fifo_rsp_t typed_rsp);
      fifo_rsp_t model_rsp;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= id;
      req_tuser  <= {kind, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_rsp = mirror_apply(act, id, kind);
      awaited_rsp.push_back(typed ? typed_rsp : model_rsp);
      @(negedge clock);
   endtask

   // Response side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Response checker
   always @(posedge clock) begin
      fifo_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: response expected none actual status=%0d id=%h kind=%0d", $time,
                     rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]);
            mismatch_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tuser[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata !== want.out_id) begin
               $display("%0t: out_id expected %h actual %h", $time, want.out_id, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[2] !== want.out_kind) begin
               $display("%0t: out_kind expected %0d actual %0d", $time, want.out_kind,
                        rsp_tuser[2]);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int          enq_pct;
      int          waited;
      int          lost;
      action_type  act;
      logic [15:0] id;
      logic        kind;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;

      // directed table: empty after reset, extremes, full, kind-selective dequeue
      add_row(ACT_DEQ_ANY, 16'h1234, 1'b1, 1, ST_EMPTY);
      add_row(ACT_DEQ_K0,  16'hFFFF, 1'b0, 1, ST_EMPTY);
      add_row(ACT_DEQ_K1,  16'h0000, 1'b1, 1, ST_EMPTY);
      add_row(ACT_ENQ,     16'hFFFF, 1'b1, 1, ST_OK);
      // other kind waiting, requested kind has nothing
      add_row(ACT_DEQ_K0,  16'h5555, 1'b1, 1, ST_EMPTY);
      for (int i = 0; i < SLOTS - 1; i++) begin
         id   = (i == 0) ? 16'h0000 : 16'(16'hA5A5 ^ (i * 16'h1357));
         kind = (i == 0) ? 1'b0 : (i[0] ^ i[2]);
         add_row(ACT_ENQ, id, kind, 1, ST_OK);
      end
      add_row(ACT_ENQ,     16'h8001, 1'b0, 1, ST_FULL);
      // pulls from behind an older entry of the other kind
      add_row(ACT_DEQ_K0,  16'h0F0F, 1'b1, 0, ST_OK);
      add_row(ACT_DEQ_ANY, 16'hF0F0, 1'b0, 0, ST_OK);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].act, dir_rows[i].id, dir_rows[i].kind, dir_rows[i].typed,
                      dir_rows[i].rsp);
      end

      // random part, enqueue share moves between phases so the queue swings full and empty
      enq_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
         if (n % 48 == 0) begin
            case ($urandom_range(0, 3))
               0: enq_pct = 15;
               1: enq_pct = 85;
               2: enq_pct = 55;
               default: enq_pct = 40;
            endcase
         end
         if (n == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (awaited_rsp.size() != 0);
         end
         act  = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ
                                                  : action_type'($urandom_range(1, 3));
         id   = 16'($urandom_range(0, 16'hFFFF));
         kind = 1'($urandom_range(0, 1));
         send_request(act, id, kind, 0, '0);
      end
      quiet = 0;
      req_tvalid <= 1'b0;

      // drain, then let the pipeline settle
      waited = 0;
      while (awaited_rsp.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      lost = awaited_rsp.size();
      if (lost != 0) begin
         $display("%0t: responses expected %0d more actual 0", $time, lost);
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && lost == 0) begin
         $display("[two_class_ordered_fifo] OK");
      end else begin
         $display("[two_class_ordered_fifo] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("[two_class_ordered_fifo] ERROR");
      $finish;
   end

endmodule
